// ===== rtl/core/bds_pkg.sv =====
`timescale 1ns / 1ps

package bds_pkg;

  // request operation codes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_e;

  // request beat
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } req_t;

  // result beat
  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [3:0]         position;
    logic signed [31:0] popped_value;
    logic [4:0]         entry_count;
  } res_t;

  // datapath actions issued by the controller
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_PUSH_FRONT,
    ACT_PUSH_BACK,
    ACT_READ_FRONT,
    ACT_READ_BACK,
    ACT_POP_FRONT,
    ACT_POP_BACK,
    ACT_SCAN_FIRST,
    ACT_SCAN_NEXT,
    ACT_RES_FULL,
    ACT_RES_EMPTY,
    ACT_RES_NOP,
    ACT_RES_HIT,
    ACT_RES_MISS
  } act_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    act_e act;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       match;
    logic       last;
  } sts_t;

endpackage

// ===== rtl/core/bds_ram.sv =====
`timescale 1ns / 1ps

module bds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/bds_ctrl.sv =====
`timescale 1ns / 1ps

module bds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bds_pkg::sts_t sts_i,
  output bds_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  import bds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_POP    = 4'b0100,
    S_SCAN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // next state and action
  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.act  = ACT_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (sts_i.op)
          OP_PUSH_FRONT: begin
            cmd_o.act = sts_i.full ? ACT_RES_FULL : ACT_PUSH_FRONT;
          end
          OP_PUSH_BACK: begin
            cmd_o.act = sts_i.full ? ACT_RES_FULL : ACT_PUSH_BACK;
          end
          OP_POP_FRONT: begin
            if (sts_i.empty) begin
              cmd_o.act = ACT_RES_EMPTY;
            end else begin
              cmd_o.act = ACT_READ_FRONT;
              state_d   = S_POP;
            end
          end
          OP_POP_BACK: begin
            if (sts_i.empty) begin
              cmd_o.act = ACT_RES_EMPTY;
            end else begin
              cmd_o.act = ACT_READ_BACK;
              state_d   = S_POP;
            end
          end
          OP_SEARCH: begin
            if (sts_i.empty) begin
              cmd_o.act = ACT_RES_EMPTY;
            end else begin
              cmd_o.act = ACT_SCAN_FIRST;
              state_d   = S_SCAN;
            end
          end
          default: begin
            cmd_o.act = ACT_RES_NOP;
          end
        endcase
      end
      S_POP: begin
        cmd_o.act = (sts_i.op == OP_POP_FRONT) ? ACT_POP_FRONT : ACT_POP_BACK;
        state_d   = S_IDLE;
      end
      S_SCAN: begin
        // one stored entry compared per cycle
        if (sts_i.match) begin
          cmd_o.act = ACT_RES_HIT;
          state_d   = S_IDLE;
        end else if (sts_i.last) begin
          cmd_o.act = ACT_RES_MISS;
          state_d   = S_IDLE;
        end else begin
          cmd_o.act = ACT_SCAN_NEXT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/core/bds_dp.sv =====
`timescale 1ns / 1ps

module bds_dp #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bds_pkg::cmd_t cmd_i,
  input  bds_pkg::req_t req_i,
  output bds_pkg::sts_t sts_o,
  output bds_pkg::res_t res_o,
  output logic          done_o
);

  import bds_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  req_t                  req_q;
  logic [IW-1:0]         front_q, front_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [IW-1:0]         slot_q, slot_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  done_q, done_d;
  res_t                  res_q, res_d;

  logic [VALUE_BITS-1:0] key;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  logic [IW-1:0]         front_dec, front_inc, slot_inc;
  logic [IW-1:0]         back_slot, last_slot;
  logic                  fin;
  logic [1:0]            fin_status;
  logic                  fin_found;
  logic [3:0]            fin_pos;
  logic signed [31:0]    fin_popped;

  // bring a sum below twice the depth back into the ring
  function automatic logic [IW-1:0] ring_wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return r[IW-1:0];
  endfunction

  // key sign-extended or cut to the stored width
  assign key = VALUE_BITS'($signed(req_q.value));

  // ring slot arithmetic
  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : (front_q - IW'(1));
  assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : (front_q + IW'(1));
  assign slot_inc  = (slot_q == IW'(DEPTH - 1)) ? '0 : (slot_q + IW'(1));
  assign back_slot = ring_wrap(SW'(front_q) + SW'(fill_q));
  assign last_slot = ring_wrap(SW'(front_q) + SW'(fill_q) - SW'(1));

  // status toward the controller
  assign sts_o.op    = req_q.operation;
  assign sts_o.empty = (fill_q == '0);
  assign sts_o.full  = (fill_q == CW'(DEPTH));
  assign sts_o.match = (rd_data == key);
  assign sts_o.last  = ((CW'(idx_q) + CW'(1)) == fill_q);

  // action decode
  always_comb begin
    front_d    = front_q;
    fill_d     = fill_q;
    slot_d     = slot_q;
    idx_d      = idx_q;
    we         = 1'b0;
    waddr      = front_q;
    raddr      = front_q;
    fin        = 1'b0;
    fin_status = ST_DONE;
    fin_found  = 1'b0;
    fin_pos    = '0;
    fin_popped = '0;
    case (cmd_i.act)
      ACT_PUSH_FRONT: begin
        front_d = front_dec;
        waddr   = front_dec;
        we      = 1'b1;
        fill_d  = fill_q + CW'(1);
        fin     = 1'b1;
      end
      ACT_PUSH_BACK: begin
        waddr  = back_slot;
        we     = 1'b1;
        fill_d = fill_q + CW'(1);
        fin    = 1'b1;
      end
      ACT_READ_FRONT: begin
        raddr = front_q;
      end
      ACT_READ_BACK: begin
        raddr = last_slot;
      end
      ACT_POP_FRONT: begin
        front_d    = front_inc;
        fill_d     = fill_q - CW'(1);
        fin        = 1'b1;
        fin_popped = $signed(32'(rd_data));
      end
      ACT_POP_BACK: begin
        fill_d     = fill_q - CW'(1);
        fin        = 1'b1;
        fin_popped = $signed(32'(rd_data));
      end
      ACT_SCAN_FIRST: begin
        raddr  = front_q;
        slot_d = front_q;
        idx_d  = '0;
      end
      ACT_SCAN_NEXT: begin
        raddr  = slot_inc;
        slot_d = slot_inc;
        idx_d  = idx_q + IW'(1);
      end
      ACT_RES_FULL: begin
        fin        = 1'b1;
        fin_status = ST_FULL;
      end
      ACT_RES_EMPTY: begin
        fin        = 1'b1;
        fin_status = ST_EMPTY;
      end
      ACT_RES_NOP: begin
        fin = 1'b1;
      end
      ACT_RES_HIT: begin
        fin       = 1'b1;
        fin_found = 1'b1;
        fin_pos   = 4'(idx_q);
      end
      ACT_RES_MISS: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // result beat assembly
  always_comb begin
    res_d  = res_q;
    done_d = fin;
    if (fin) begin
      res_d.status       = fin_status;
      res_d.found        = fin_found;
      res_d.position     = fin_pos;
      res_d.popped_value = fin_popped;
      res_d.entry_count  = 5'(fill_d);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      front_q <= front_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    slot_q <= slot_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  bds_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (key),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/bounded_deque_search.sv =====
`timescale 1ns / 1ps

// Bounded deque of signed words in a ring memory with a linear search from
// the front. A request is taken when start is high and busy is low; its single
// result appears on res_o for exactly one cycle with done_o high, and the
// receiver cannot hold it off. A push, a failed request or an unused operation
// code is settled in the decode state; a pop first reads the entry memory once,
// and a search reads and compares the stored entries in order from the front
// until one matches or the last one is passed. The single read port of the
// entry memory delivers one stored entry per cycle to the comparator. The
// entry memory needs no clearing after reset.
module bounded_deque_search #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bds_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output bds_pkg::res_t res_o
);

  import bds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  bds_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // pointers, entry memory and result register
  bds_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .sts_o  (sts),
    .res_o  (res_o),
    .done_o (done_o)
  );

endmodule

// ===== rtl/core/bds_checker.sv =====
`timescale 1ns / 1ps

module bds_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_i,
  input bds_pkg::res_t res_i
);

  import bds_pkg::*;

  // an accepted beat always occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // no two result beats in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe on consecutive cycles");

  // an empty failure leaves nothing held and no payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && res_i.status == ST_EMPTY) |->
      (res_i.entry_count == 5'd0 && !res_i.found && res_i.popped_value == 32'sd0))
    else $error("empty failure with stale fields");

  // a hit is always a completed request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && res_i.found) |-> (res_i.status == ST_DONE && res_i.popped_value == 32'sd0))
    else $error("found flag on a failed or pop result");

endmodule

bind bounded_deque_search bds_checker u_bds_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_i (done_o),
  .res_i  (res_o)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bds_pkg::*;

  localparam int DEPTH = 16;

  // operation codes the block ignores
  localparam logic [2:0] OP_RESERVED_5 = 3'd5;
  localparam logic [2:0] OP_RESERVED_7 = 3'd7;

  // shadow copy of the deque plus the results it still owes
  class deque_mirror;
    logic signed [31:0] ring [DEPTH];
    int unsigned        head;
    int unsigned        fill;
    res_t               due_results [$];
    int                 errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function logic signed [31:0] held_at(int unsigned pos);
      return ring[(head + pos) % DEPTH];
    endfunction

    // update the shadow list for one accepted request beat
    function void note_request(req_t r);
      res_t        e;
      int unsigned i;
      e = '0;
      case (r.operation)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill == DEPTH) begin
            e.status = ST_FULL;
          end else if (r.operation == OP_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = r.value;
            fill++;
          end else begin
            ring[(head + fill) % DEPTH] = r.value;
            fill++;
          end
        end
        OP_POP_FRONT: begin
          if (fill == 0) begin
            e.status = ST_EMPTY;
          end else begin
            e.popped_value = ring[head];
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        OP_POP_BACK: begin
          if (fill == 0) begin
            e.status = ST_EMPTY;
          end else begin
            e.popped_value = ring[(head + fill - 1) % DEPTH];
            fill--;
          end
        end
        OP_SEARCH: begin
          if (fill == 0) begin
            e.status = ST_EMPTY;
          end else begin
            for (i = 0; i < fill; i++) begin
              if (ring[(head + i) % DEPTH] == r.value) begin
                e.found    = 1'b1;
                e.position = 4'(i);
                break;
              end
            end
          end
        end
        default: begin
          // unused code: nothing changes
        end
      endcase
      e.entry_count = 5'(fill);
      due_results.push_back(e);
    endfunction

    // compare one result beat against the oldest owed result
    function void compare_result(res_t got);
      res_t e;
      if (due_results.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, got.found);
        errors++;
      end
      if (got.position !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, got.position);
        errors++;
      end
      if (got.popped_value !== e.popped_value) begin
        $error("popped_value: expected %0d, got %0d", e.popped_value, got.popped_value);
        errors++;
      end
      if (got.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start  = 1'b0;
  req_t  req_i  = '0;
  logic  busy;
  logic  done_o;
  res_t  res_o;

  deque_mirror mirror = new();
  bit          calm   = 1'b0;

  bounded_deque_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watch both sides of the handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) mirror.compare_result(res_o);
      if (start && !busy) mirror.note_request(req_i);
    end
  end

  // present one request beat and hold it until taken
  task automatic issue(logic [2:0] op, logic signed [31:0] val);
    if (!calm && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start           <= 1'b1;
    req_i.operation <= op;
    req_i.value     <= val;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending until every owed result has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0]         op;
    logic signed [31:0] val;
    int                 n;
    int                 roll;
    int                 pick;
    bit                 growing;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cases, extremes, full cases, deepest search hit
    issue(OP_SEARCH, 32'sd5);
    issue(OP_POP_FRONT, 32'sd0);
    issue(OP_POP_BACK, -32'sd1);
    issue(OP_PUSH_FRONT, 32'sh80000000);
    issue(OP_PUSH_BACK, 32'sh7fffffff);
    issue(OP_RESERVED_7, 32'sd9);
    for (n = 0; n < DEPTH - 2; n++) issue(OP_PUSH_BACK, 32'(n * 3 + 1));
    issue(OP_PUSH_FRONT, -32'sd2);
    issue(OP_PUSH_BACK, 32'sd2);
    issue(OP_SEARCH, 32'((DEPTH - 3) * 3 + 1));
    issue(OP_SEARCH, 32'sh5a5a5a5a);
    issue(OP_POP_FRONT, 32'sd0);
    issue(OP_POP_BACK, 32'sd0);
    settle();

    // random: sweep the fill level up and down with searches mixed in
    growing = 1'b1;
    for (n = 0; n < 700; n++) begin
      calm = (n >= 250 && n < 400);
      if (mirror.fill >= DEPTH) growing = 1'b0;
      else if (mirror.fill == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;

      roll = $urandom_range(0, 99);
      if (roll < 3) op = 3'($urandom_range(OP_RESERVED_5, OP_RESERVED_7));
      else if (roll < 28) op = OP_SEARCH;
      else if (roll < (growing ? 82 : 46))
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;

      // small values repeat often so searches hit duplicates
      pick = $urandom_range(0, 9);
      if (op == OP_SEARCH && mirror.fill > 0 && pick < 6)
        val = mirror.held_at($urandom_range(0, mirror.fill - 1));
      else if (pick < 5)
        val = int'($urandom_range(0, 15)) - 8;
      else if (pick == 5)
        val = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else
        val = $urandom();

      issue(op, val);
      if (n % 233 == 232) settle();
    end

    // drain and let the block go quiet
    settle();
    repeat (2 * DEPTH) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
